/* rtl/fastq_kmer_extractor_top_defines.svh */
// Assertion macros shared by the RTL
`ifndef FASTQ_KMER_EXTRACTOR_TOP_DEFINES_SVH
`define FASTQ_KMER_EXTRACTOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FKE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FKE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fke_pkg.sv */
`default_nettype none

package fke_pkg;

    localparam int KMER_W  = 64;
    localparam int MASK_W  = 32;
    localparam int K_W     = 6;
    localparam int BYTE_W  = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [K_W-1:0] K_RESET = 6'd21;

    // register word index (paddr[2])
    localparam logic REG_K = 1'b0;

    localparam logic [BYTE_W-1:0] CHAR_AT   = 8'h40;  // '@'
    localparam logic [BYTE_W-1:0] CHAR_PLUS = 8'h2B;  // '+'
    localparam logic [BYTE_W-1:0] CHAR_NL   = 8'h0A;  // newline
    localparam logic [BYTE_W-1:0] CHAR_UA   = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UC   = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_UG   = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_UT   = 8'h54;
    localparam logic [BYTE_W-1:0] CHAR_LA   = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LC   = 8'h63;
    localparam logic [BYTE_W-1:0] CHAR_LG   = 8'h67;
    localparam logic [BYTE_W-1:0] CHAR_LT   = 8'h74;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SCAN  = 2'd1,
        PH_SKIP  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       is_base;
        logic       lower;
        logic [1:0] code;
    } base_t;

endpackage

`default_nettype wire

/* rtl/fastq_kmer_extractor_top.sv */
// Each k-mer is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one byte per cycle while the skid register is empty; a stalled output parks one result in it.
// in_ready depends only on the skid register, so no ready path runs through the block.
// Reset (rst_n, async, active low): run cleared, sequence mode on, line start, k = 21.
`default_nettype none

`include "fastq_kmer_extractor_top_defines.svh"

module fastq_kmer_extractor_top
    import fke_pkg::*;
#(
    parameter int MAX_K = 32    // 1..32 bases
)
(
    input  wire                   clk,
    input  wire                   rst_n,

    // APB-style configuration port
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_AW-1:0]     paddr,
    input  wire  [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,

    // byte stream in
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  [BYTE_W-1:0]     in_byte,

    // k-mer results out
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic [KMER_W-1:0]     kmer_code,
    output logic [MASK_W-1:0]     lower_mask
);

    localparam int CODE_W = 2 * MAX_K;
    localparam int RUN_W  = $clog2(MAX_K + 1);
    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_K);
    localparam logic [K_W-1:0]   K_MAX   = K_W'(MAX_K);

    // ------------------------------------------------------------------
    // Configuration: single register k at word 0. Words past it read zero
    // and ignore writes.
    // ------------------------------------------------------------------
    logic [K_W-1:0] k_reg;
    logic           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_K))
        begin
            k_reg <= pwdata[K_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_K)
        begin
            prdata = APB_DW'(k_reg);
        end
    end

    // Effective length: 0 behaves as 1, anything above MAX_K as MAX_K.
    logic [K_W-1:0] kk;
    always_comb
    begin
        kk = k_reg;
        if (k_reg == '0)
        begin
            kk = K_W'(1);
        end
        else if (k_reg > K_MAX)
        begin
            kk = K_MAX;
        end
    end

    // Window masks follow kk; the user must make k changes only while idle; the block does not enforce it.
    logic [MAX_K-1:0]  lmask;
    logic [CODE_W-1:0] cmask;
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            lmask[i]         = (K_W'(i) < kk);
            cmask[2*i +: 2]  = {2{lmask[i]}};
        end
    end

    // ------------------------------------------------------------------
    // Line state and run shift registers
    // ------------------------------------------------------------------
    phase_t            phase_reg,  phase_next;
    logic              seq_reg,    seq_next;
    logic              scan_now;
    logic [CODE_W-1:0] base_reg,   base_next;
    logic [MAX_K-1:0]  case_reg,   case_next;
    logic [RUN_W-1:0]  run_reg,    run_next;
    logic              in_fire;
    logic              emit;
    base_t             dec;

    assign in_fire = in_valid && in_ready;

    // ACGT in either case; everything else breaks the run
    always_comb
    begin
        dec = '{is_base: 1'b1, lower: 1'b0, code: CODE_A};
        case (in_byte)
            CHAR_UA: dec.code = CODE_A;
            CHAR_UC: dec.code = CODE_C;
            CHAR_UG: dec.code = CODE_G;
            CHAR_UT: dec.code = CODE_T;
            CHAR_LA: dec = '{is_base: 1'b1, lower: 1'b1, code: CODE_A};
            CHAR_LC: dec = '{is_base: 1'b1, lower: 1'b1, code: CODE_C};
            CHAR_LG: dec = '{is_base: 1'b1, lower: 1'b1, code: CODE_G};
            CHAR_LT: dec = '{is_base: 1'b1, lower: 1'b1, code: CODE_T};
            default: dec.is_base = 1'b0;
        endcase
    end

    // Line phase: next state. Header ('@') and separator ('+') lines are
    // skipped and switch sequence mode; a newline always returns to start.
    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        if (in_byte == CHAR_NL)
        begin
            phase_next = PH_START;
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (in_byte == CHAR_AT)
                    begin
                        seq_next   = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else if (in_byte == CHAR_PLUS)
                    begin
                        seq_next   = 1'b0;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = seq_reg ? PH_SCAN : PH_SKIP;
                    end
                end
                PH_SCAN: phase_next = PH_SCAN;
                PH_SKIP: phase_next = PH_SKIP;
                default: phase_next = PH_SKIP;
            endcase
        end
    end

    // Line phase: outputs. The first byte of a sequence line is scanned too.
    always_comb
    begin
        scan_now = 1'b0;
        if (in_byte != CHAR_NL)
        begin
            unique case (phase_reg)
                PH_START: scan_now = seq_reg && (in_byte != CHAR_AT) &&
                                     (in_byte != CHAR_PLUS);
                PH_SCAN:  scan_now = 1'b1;
                PH_SKIP:  scan_now = 1'b0;
                default:  scan_now = 1'b0;
            endcase
        end
    end

    // Run datapath: clear on newline; while scanning, shift in a base or clear on a non-base byte.
    always_comb
    begin
        base_next = base_reg;
        case_next = case_reg;
        run_next  = run_reg;
        emit      = 1'b0;
        if (in_byte == CHAR_NL)
        begin
            base_next = '0;
            case_next = '0;
            run_next  = '0;
        end
        else if (scan_now)
        begin
            if (dec.is_base)
            begin
                // oldest base drops off the top
                base_next = CODE_W'({base_reg, dec.code});
                case_next = MAX_K'({case_reg, dec.lower});
                if (run_reg != RUN_MAX)
                begin
                    run_next = run_reg + RUN_W'(1);
                end
                emit = (K_W'(run_next) >= kk);
            end
            else
            begin
                base_next = '0;
                case_next = '0;
                run_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            seq_reg   <= 1'b1;
            base_reg  <= '0;
            case_reg  <= '0;
            run_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
            base_reg  <= base_next;
            case_reg  <= case_next;
            run_reg   <= run_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register plus skid register. A new request is taken whenever
    // the skid is empty; the skid only fills when the output is stalled.
    // ------------------------------------------------------------------
    logic              out_valid_reg,  out_valid_next;
    logic [CODE_W-1:0] out_code_reg,   out_code_next;
    logic [MAX_K-1:0]  out_mask_reg,   out_mask_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [CODE_W-1:0] skid_code_reg,  skid_code_next;
    logic [MAX_K-1:0]  skid_mask_reg,  skid_mask_next;
    logic              new_res;
    logic              out_free;
    logic [CODE_W-1:0] res_code;
    logic [MAX_K-1:0]  res_mask;

    assign new_res  = in_fire && emit;
    assign res_code = base_next & cmask;
    assign res_mask = case_next & lmask;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        out_mask_next   = out_mask_reg;
        skid_valid_next = skid_valid_reg;
        skid_code_next  = skid_code_reg;
        skid_mask_next  = skid_mask_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // skid full means no request was taken this cycle
                out_valid_next  = 1'b1;
                out_code_next   = skid_code_reg;
                out_mask_next   = skid_mask_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = new_res;
                out_code_next  = res_code;
                out_mask_next  = res_mask;
            end
        end
        else if (new_res)
        begin
            skid_valid_next = 1'b1;
            skid_code_next  = res_code;
            skid_mask_next  = res_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg  <= out_code_next;
        out_mask_reg  <= out_mask_next;
        skid_code_reg <= skid_code_next;
        skid_mask_reg <= skid_mask_next;
    end

    assign out_valid  = out_valid_reg;
    assign kmer_code  = KMER_W'(out_code_reg);
    assign lower_mask = MASK_W'(out_mask_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FKE_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid holds a result while output register is empty")
    `FKE_ASSERT_NOW(a_run_clear, run_reg == '0, (base_reg == '0) && (case_reg == '0),
        "empty run with stale shift contents")
    `FKE_ASSERT_NEXT(a_nl_clears, in_fire && (in_byte == CHAR_NL),
        (run_reg == '0) && (phase_reg == PH_START),
        "newline did not reset the line state")
    `FKE_ASSERT_NOW(a_seq_off, $fell(seq_reg),
        $past(in_fire) && ($past(in_byte) == CHAR_PLUS),
        "sequence mode dropped without a separator line")

endmodule

`default_nettype wire
